>>> hdl/lwcd_pkg.sv
// ----------------------------------------------------------------------------
// LRU write-back cache directory package
// Sizes, function and action codes, and the structs that pass between the
// slot store, the slot scan unit and the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lwcd_pkg;

   localparam int SLOTS           = 16;
   localparam int ITEMS_PER_BLOCK = 32;
   localparam int ITEM_BYTES      = 128;

   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int CNT_W   = $clog2(SLOTS + 1);
   localparam int FUNC_W  = 3;
   localparam int ACT_W   = 3;
   localparam int WORD_W  = 32;
   localparam int OFF_W   = 12;

   localparam logic [WORD_W-1:0] TS_NONE = 32'hFFFF_FFFF;

   // Request function codes.
   localparam logic [FUNC_W-1:0] FN_READ  = 3'd0;
   localparam logic [FUNC_W-1:0] FN_WRITE = 3'd1;
   localparam logic [FUNC_W-1:0] FN_WTHRU = 3'd2;
   localparam logic [FUNC_W-1:0] FN_EVICT = 3'd3;
   localparam logic [FUNC_W-1:0] FN_FLUSH = 3'd4;
   localparam logic [FUNC_W-1:0] FN_INVAL = 3'd5;

   // Result action codes.
   localparam logic [ACT_W-1:0] ACT_DONE   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_WB     = 3'd1;
   localparam logic [ACT_W-1:0] ACT_FILL   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_DWRITE = 3'd3;
   localparam logic [ACT_W-1:0] ACT_REJECT = 3'd4;

   typedef logic [SLOT_W-1:0] slot_idx_type;
   typedef logic [WORD_W-1:0] word_type;

   // One write into the slot store; each field group has its own enable.
   typedef struct packed {
      logic         tag_we;
      logic         dirty_we;
      logic         last_we;
      slot_idx_type idx;
      word_type     tag;
      logic         dirty;
      word_type     last_use;
   } lwcd_wr_type;

   // Outcome of one pass of the scan unit over all slots.
   typedef struct packed {
      logic         hit;
      slot_idx_type hit_idx;
      slot_idx_type victim_idx;
   } lwcd_scan_type;

endpackage

>>> hdl/lwcd_slot_store.sv
// ----------------------------------------------------------------------------
// Slot store
// Tag, dirty bit and last-use timestamp of every slot, with one read port
// and one write port, plus a clear of the whole directory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lwcd_slot_store (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear_all,
   input  lwcd_pkg::lwcd_wr_type wr,
   input  lwcd_pkg::slot_idx_type rd_idx,
   output lwcd_pkg::word_type   rd_tag,
   output logic                 rd_dirty,
   output lwcd_pkg::word_type   rd_last_use
);
   import lwcd_pkg::*;

   word_type tag_ff   [SLOTS];
   logic     dirty_ff [SLOTS];
   word_type last_ff  [SLOTS];

   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         for (int i = 0; i < SLOTS; i++) begin
            tag_ff[i]   <= '0;
            dirty_ff[i] <= 1'b0;
            last_ff[i]  <= '0;
         end
      end else begin
         if (wr.tag_we) begin
            tag_ff[wr.idx] <= wr.tag;
         end
         if (wr.dirty_we) begin
            dirty_ff[wr.idx] <= wr.dirty;
         end
         if (wr.last_we) begin
            last_ff[wr.idx] <= wr.last_use;
         end
      end
   end

   assign rd_tag      = tag_ff[rd_idx];
   assign rd_dirty    = dirty_ff[rd_idx];
   assign rd_last_use = last_ff[rd_idx];

endmodule

>>> hdl/lwcd_scan_unit.sv
// ----------------------------------------------------------------------------
// Slot scan unit
// Compares one slot per cycle while step is high against the key, and tracks
// the first match, the first empty slot and the oldest timestamp over a pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lwcd_scan_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   step,
   input  lwcd_pkg::word_type     key,
   input  lwcd_pkg::slot_idx_type idx,
   input  lwcd_pkg::word_type     tag,
   input  lwcd_pkg::word_type     last_use,
   output lwcd_pkg::lwcd_scan_type result
);
   import lwcd_pkg::*;

   logic         hit_ff, hit_in;
   slot_idx_type hit_idx_ff, hit_idx_in;
   logic         empty_ff, empty_in;
   slot_idx_type empty_idx_ff, empty_idx_in;
   word_type     oldest_ff, oldest_in;
   slot_idx_type min_idx_ff, min_idx_in;

   always_comb begin
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      empty_in     = empty_ff;
      empty_idx_in = empty_idx_ff;
      oldest_in    = oldest_ff;
      min_idx_in   = min_idx_ff;
      if (start) begin
         hit_in     = 1'b0;
         empty_in   = 1'b0;
         oldest_in  = TS_NONE;
         min_idx_in = '0;
      end else if (step) begin
         if (!hit_ff && tag == key) begin
            hit_in     = 1'b1;
            hit_idx_in = idx;
         end
         if (!empty_ff && tag == '0) begin
            empty_in     = 1'b1;
            empty_idx_in = idx;
         end
         // Strict compare keeps the lowest index on equal timestamps.
         if (last_use < oldest_ff) begin
            oldest_in  = last_use;
            min_idx_in = idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff   <= 1'b0;
         empty_ff <= 1'b0;
      end else begin
         hit_ff   <= hit_in;
         empty_ff <= empty_in;
      end
      hit_idx_ff   <= hit_idx_in;
      empty_idx_ff <= empty_idx_in;
      oldest_ff    <= oldest_in;
      min_idx_ff   <= min_idx_in;
   end

   assign result.hit        = hit_ff;
   assign result.hit_idx    = hit_idx_ff;
   assign result.victim_idx = empty_ff ? empty_idx_ff : min_idx_ff;

endmodule

>>> hdl/lru_writeback_cache_directory_core.sv
// ----------------------------------------------------------------------------
// LRU write-back cache directory core
// Directory of a 16-slot fully associative write-back cache keyed by item
// number. Each request is one of read, write, write-through, evict, flush all
// or invalidate all, and produces one or more responses on the rsp_ channel;
// rsp_last marks the final one. Write-back, fill and disk-write responses
// carry the item, its disk block and its byte offset in that block; payload
// data live outside, addressed by rsp_slot_index. Requests are handled one at
// a time: a lookup steps a single compare unit through the slots, one per
// cycle. Flush all visits one slot per cycle, holding a slot while its
// write-back waits on response backpressure, and issues each write-back in
// the cycle of its slot. Response backpressure can stall any step that
// emits a response. The table start block register may be written through
// the csr_ port while no request is active.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_writeback_cache_directory_core (
   input  logic                           clock,
   input  logic                           reset,
   // configuration
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  lwcd_pkg::word_type             csr_table_start_block,
   // requests
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lwcd_pkg::FUNC_W-1:0]    req_func,
   input  lwcd_pkg::word_type             req_item_number,
   input  lwcd_pkg::word_type             req_now_tick,
   // responses
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lwcd_pkg::ACT_W-1:0]     rsp_action,
   output lwcd_pkg::slot_idx_type         rsp_slot_index,
   output lwcd_pkg::word_type             rsp_request_item,
   output lwcd_pkg::word_type             rsp_disk_block,
   output logic [lwcd_pkg::OFF_W-1:0]     rsp_byte_offset,
   output logic [lwcd_pkg::CNT_W-1:0]     rsp_writeback_count,
   output logic                           rsp_last
);
   import lwcd_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SCAN    = 3'd1;
   localparam logic [2:0] S_DECIDE  = 3'd2;
   localparam logic [2:0] S_VICTIM  = 3'd3;
   localparam logic [2:0] S_INSTALL = 3'd4;
   localparam logic [2:0] S_FLUSH   = 3'd5;
   localparam logic [2:0] S_REPLY   = 3'd6;

   localparam slot_idx_type LAST_IDX = SLOT_W'(SLOTS - 1);

   function automatic word_type disk_block_of(word_type start, word_type item);
      return start + item / ITEMS_PER_BLOCK;
   endfunction

   function automatic logic [OFF_W-1:0] byte_offset_of(word_type item);
      return OFF_W'((item % ITEMS_PER_BLOCK) * ITEM_BYTES);
   endfunction

   logic [2:0]          state_ff, state_in;
   slot_idx_type        idx_ff, idx_in;
   slot_idx_type        victim_ff, victim_in;
   logic [FUNC_W-1:0]   func_ff, func_in;
   word_type            item_ff, item_in;
   word_type            now_ff, now_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [ACT_W-1:0]    reply_ff, reply_in;
   word_type            start_blk_ff, start_blk_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ACT_W-1:0]    act_ff;
   slot_idx_type        slot_ff;
   word_type            ritem_ff;
   word_type            blk_ff;
   logic [OFF_W-1:0]    off_ff;
   logic [CNT_W-1:0]    wbcnt_ff;
   logic                last_ff;

   logic                req_accept;
   logic                out_free;
   logic                emit_en;
   logic [ACT_W-1:0]    emit_act;
   slot_idx_type        emit_slot;
   word_type            emit_item;
   logic                emit_disk;
   logic [CNT_W-1:0]    emit_cnt;
   logic                emit_last;

   logic                clear_all;
   lwcd_wr_type         wr;
   slot_idx_type        rd_idx;
   word_type            rd_tag;
   logic                rd_dirty;
   word_type            rd_last_use;
   logic                scan_start;
   logic                scan_step;
   lwcd_scan_type       scan_res;
   logic                need_wb;

   lwcd_slot_store u_store (
      .clock       (clock),
      .reset       (reset),
      .clear_all   (clear_all),
      .wr          (wr),
      .rd_idx      (rd_idx),
      .rd_tag      (rd_tag),
      .rd_dirty    (rd_dirty),
      .rd_last_use (rd_last_use)
   );

   lwcd_scan_unit u_scan (
      .clock    (clock),
      .reset    (reset),
      .start    (scan_start),
      .step     (scan_step),
      .key      (item_ff),
      .idx      (idx_ff),
      .tag      (rd_tag),
      .last_use (rd_last_use),
      .result   (scan_res)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign need_wb    = (rd_tag != '0) && rd_dirty;

   assign start_blk_in = (csr_valid && csr_ready) ? csr_table_start_block : start_blk_ff;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      victim_in  = victim_ff;
      func_in    = func_ff;
      item_in    = item_ff;
      now_in     = now_ff;
      cnt_in     = cnt_ff;
      reply_in   = reply_ff;
      emit_en    = 1'b0;
      emit_act   = ACT_DONE;
      emit_slot  = '0;
      emit_item  = '0;
      emit_disk  = 1'b0;
      emit_cnt   = '0;
      emit_last  = 1'b0;
      clear_all  = 1'b0;
      wr         = '0;
      rd_idx     = idx_ff;
      scan_start = 1'b0;
      scan_step  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               func_in = req_func;
               item_in = req_item_number;
               now_in  = req_now_tick;
               cnt_in  = '0;
               idx_in  = '0;
               priority if (req_func > FN_INVAL ||
                            (req_func <= FN_WTHRU && req_item_number == '0)) begin
                  reply_in = ACT_REJECT;
                  state_in = S_REPLY;
               end else if (req_func == FN_INVAL) begin
                  clear_all = 1'b1;
                  reply_in  = ACT_DONE;
                  state_in  = S_REPLY;
               end else if (req_func == FN_FLUSH) begin
                  state_in = S_FLUSH;
               end else begin
                  scan_start = 1'b1;
                  state_in   = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            scan_step = 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = S_DECIDE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DECIDE: begin
            priority if (func_ff == FN_EVICT) begin
               // An evict of item 0 matches the first empty slot, which is harmless.
               if (out_free) begin
                  emit_en   = 1'b1;
                  emit_last = 1'b1;
                  if (scan_res.hit) begin
                     emit_slot   = scan_res.hit_idx;
                     wr.idx      = scan_res.hit_idx;
                     wr.tag_we   = 1'b1;
                     wr.dirty_we = 1'b1;
                  end
                  state_in = S_IDLE;
               end
            end else if (scan_res.hit) begin
               if (out_free) begin
                  wr.idx      = scan_res.hit_idx;
                  wr.last_we  = 1'b1;
                  wr.last_use = now_ff;
                  wr.dirty_we = (func_ff != FN_READ);
                  wr.dirty    = (func_ff == FN_WRITE);
                  emit_en     = 1'b1;
                  emit_last   = 1'b1;
                  emit_slot   = scan_res.hit_idx;
                  if (func_ff == FN_WTHRU) begin
                     emit_act  = ACT_DWRITE;
                     emit_item = item_ff;
                     emit_disk = 1'b1;
                  end
                  state_in = S_IDLE;
               end
            end else begin
               victim_in = scan_res.victim_idx;
               state_in  = S_VICTIM;
            end
         end
         S_VICTIM: begin
            rd_idx = victim_ff;
            if (!need_wb) begin
               state_in = S_INSTALL;
            end else if (out_free) begin
               emit_en   = 1'b1;
               emit_act  = ACT_WB;
               emit_slot = victim_ff;
               emit_item = rd_tag;
               emit_disk = 1'b1;
               state_in  = S_INSTALL;
            end
         end
         S_INSTALL: begin
            if (out_free) begin
               wr.idx      = victim_ff;
               wr.tag_we   = 1'b1;
               wr.tag      = item_ff;
               wr.dirty_we = 1'b1;
               wr.dirty    = (func_ff == FN_WRITE);
               wr.last_we  = 1'b1;
               wr.last_use = now_ff;
               emit_en     = 1'b1;
               emit_last   = 1'b1;
               emit_slot   = victim_ff;
               if (func_ff == FN_READ) begin
                  emit_act  = ACT_FILL;
                  emit_item = item_ff;
                  emit_disk = 1'b1;
               end else if (func_ff == FN_WTHRU) begin
                  emit_act  = ACT_DWRITE;
                  emit_item = item_ff;
                  emit_disk = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (!need_wb || out_free) begin
               if (need_wb) begin
                  emit_en     = 1'b1;
                  emit_act    = ACT_WB;
                  emit_slot   = idx_ff;
                  emit_item   = rd_tag;
                  emit_disk   = 1'b1;
                  wr.idx      = idx_ff;
                  wr.dirty_we = 1'b1;
                  cnt_in      = cnt_ff + 1'b1;
               end
               if (idx_ff == LAST_IDX) begin
                  reply_in = ACT_DONE;
                  state_in = S_REPLY;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_REPLY: begin
            if (out_free) begin
               emit_en   = 1'b1;
               emit_act  = reply_ff;
               emit_cnt  = cnt_ff;
               emit_last = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = emit_en || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         start_blk_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         start_blk_ff <= start_blk_in;
      end
      idx_ff    <= idx_in;
      victim_ff <= victim_in;
      func_ff   <= func_in;
      item_ff   <= item_in;
      now_ff    <= now_in;
      cnt_ff    <= cnt_in;
      reply_ff  <= reply_in;
      if (emit_en) begin
         act_ff   <= emit_act;
         slot_ff  <= emit_slot;
         ritem_ff <= emit_disk ? emit_item : '0;
         blk_ff   <= emit_disk ? disk_block_of(start_blk_ff, emit_item) : '0;
         off_ff   <= emit_disk ? byte_offset_of(emit_item) : '0;
         wbcnt_ff <= emit_cnt;
         last_ff  <= emit_last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_action          = act_ff;
   assign rsp_slot_index      = slot_ff;
   assign rsp_request_item    = ritem_ff;
   assign rsp_disk_block      = blk_ff;
   assign rsp_byte_offset     = off_ff;
   assign rsp_writeback_count = wbcnt_ff;
   assign rsp_last            = last_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff != S_IDLE)
      else $error("request accepted but sequencer did not leave idle");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit_en |-> out_free)
      else $error("response emitted while a stalled response is pending");

   a_wb_not_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && act_ff == ACT_WB |-> !last_ff)
      else $error("write-back response marked as final");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN && idx_ff == LAST_IDX |=> state_ff == S_DECIDE)
      else $error("slot scan did not end after the last slot");

endmodule
